/* design/lkv_pkg.sv */
// Shared types, codes and constants of the linear key-value table.
package lkv_pkg;

  // Default number of entries the table can hold.
  localparam int CAPACITY_DEF = 64;

  // Widths of the fixed payload fields.
  localparam int OP_W    = 3;
  localparam int DATA_W  = 32;
  localparam int TOTAL_W = 7;

  // Operation codes; codes without a member behave as a peek.
  typedef enum logic [OP_W-1:0] {
    OP_ACCESS = 3'd0,
    OP_WRITE  = 3'd1,
    OP_PEEK   = 3'd2,
    OP_ERASE  = 3'd3,
    OP_CLEAR  = 3'd4
  } lkv_op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } lkv_status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_RESOLVE,
    S_SHIFT,
    S_DONE
  } lkv_state_t;

  // One stored pair.
  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } lkv_entry_t;

  // One result word.
  typedef struct packed {
    logic [DATA_W-1:0]  read_value;
    logic               was_present;
    lkv_status_t        status;
    logic [TOTAL_W-1:0] entry_total;
  } lkv_result_t;

endpackage

/* design/lkv_in_if.sv */
// Input channel of the key-value table: valid/ready plus the request word.
interface lkv_in_if import lkv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] write_value;

  modport source (output valid, output operation, output key, output write_value,
                  input ready);
  modport sink (input valid, input operation, input key, input write_value,
                output ready);
endinterface

/* design/lkv_out_if.sv */
// Result channel of the key-value table: valid/ready plus the result word.
interface lkv_out_if import lkv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic                     was_present;
  logic [1:0]               status;
  logic [TOTAL_W-1:0]       entry_total;

  modport source (output valid, output read_value, output was_present, output status,
                  output entry_total, input ready);
  modport sink (input valid, input read_value, input was_present, input status,
                input entry_total, output ready);
endinterface

/* design/linear_key_value_table.sv */
// Every operation but clear scans the stored entries in order until the key is found or
// all are checked; erase then shifts each entry after the hit down one place.
// Clear skips the search. A new word is taken only once the last result is registered.
// The single read port of the pair memory sets the pace, one entry per cycle.
// Reset (synchronous, active low) empties the table; the pair memory is not cleared.
module linear_key_value_table import lkv_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lkv_in_if.sink     in_chan,
  lkv_out_if.source  out_chan
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  lkv_entry_t    mem_wdata;
  logic [AW-1:0] mem_raddr;
  lkv_entry_t    mem_rdata;
  logic          res_valid;
  lkv_result_t   res;
  logic          out_free;
  logic          out_valid_r, out_valid_nxt;
  lkv_result_t   out_res_r;

  lkv_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lkv_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Output register: free once empty or being taken this cycle.
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.read_value  = out_res_r.read_value;
  assign out_chan.was_present = out_res_r.was_present;
  assign out_chan.status      = out_res_r.status;
  assign out_chan.entry_total = out_res_r.entry_total;

endmodule

/* design/lkv_store.sv */
// Pair memory: one write port and one read port with registered read data.
module lkv_store import lkv_pkg::*; #(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  lkv_entry_t    wdata,
  input  logic [AW-1:0] raddr,
  output lkv_entry_t    rdata
);

  lkv_entry_t mem [DEPTH];
  lkv_entry_t rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/lkv_seq.sv */
// Sequencer: linear search, insert, update and erase-with-shift over the pair memory.
module lkv_seq import lkv_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  lkv_in_if.sink        in_chan,
  input  logic          out_free,
  output logic          res_valid,
  output lkv_result_t   res,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output lkv_entry_t    mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  lkv_entry_t    mem_rdata
);

  lkv_state_t        state_r, state_nxt;
  lkv_op_t           op_r, op_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0] wval_r, wval_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     scan_r, scan_nxt;
  logic              chk_valid_r, chk_valid_nxt;
  logic [AW-1:0]     chk_idx_r, chk_idx_nxt;
  logic              hit_r, hit_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  lkv_result_t       res_r, res_nxt;
  logic              match;

  // The word read last cycle holds the searched key.
  assign match = chk_valid_r && (mem_rdata.key == key_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = (lkv_op_t'(in_chan.operation) == OP_CLEAR) ? S_DONE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (match || (scan_r == count_r)) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        state_nxt = ((op_r == OP_ERASE) && hit_r) ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        if (!chk_valid_r && (scan_r >= count_r)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory control and handshake outputs.
  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    wval_nxt      = wval_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    chk_valid_nxt = chk_valid_r;
    chk_idx_nxt   = chk_idx_r;
    hit_nxt       = hit_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = '{key: key_r, value: wval_r};
    mem_raddr     = scan_r[AW-1:0];
    res_valid     = 1'b0;
    in_chan.ready = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt        = lkv_op_t'(in_chan.operation);
          key_nxt       = in_chan.key;
          wval_nxt      = in_chan.write_value;
          scan_nxt      = '0;
          chk_valid_nxt = 1'b0;
          if (lkv_op_t'(in_chan.operation) == OP_CLEAR) begin
            count_nxt = '0;
            res_nxt   = '{read_value: '0, was_present: 1'b0, status: ST_OK,
                          entry_total: '0};
          end
        end
      end

      // One entry read per cycle; the compare sees the previous read.
      S_SEARCH: begin
        if (match) begin
          hit_nxt = 1'b1;
          idx_nxt = chk_idx_r;
          val_nxt = mem_rdata.value;
        end else if (scan_r == count_r) begin
          hit_nxt = 1'b0;
        end else begin
          chk_valid_nxt = 1'b1;
          chk_idx_nxt   = scan_r[AW-1:0];
          scan_nxt      = scan_r + CW'(1);
        end
      end

      // Act on the search outcome.
      S_RESOLVE: begin
        res_nxt.read_value  = '0;
        res_nxt.was_present = hit_r;
        res_nxt.status      = ST_OK;
        res_nxt.entry_total = TOTAL_W'(count_r);
        case (op_r)
          OP_ACCESS, OP_WRITE: begin
            if (hit_r) begin
              if (op_r == OP_WRITE) begin
                mem_we             = 1'b1;
                mem_waddr          = idx_r;
                mem_wdata          = '{key: key_r, value: wval_r};
                res_nxt.read_value = wval_r;
              end else begin
                res_nxt.read_value = val_r;
              end
            end else if (count_r == CW'(CAPACITY)) begin
              res_nxt.status = ST_FULL;
            end else begin
              mem_we              = 1'b1;
              mem_waddr           = count_r[AW-1:0];
              mem_wdata           = '{key: key_r,
                                      value: (op_r == OP_WRITE) ? wval_r : '0};
              count_nxt           = count_r + CW'(1);
              res_nxt.read_value  = (op_r == OP_WRITE) ? wval_r : '0;
              res_nxt.entry_total = TOTAL_W'(count_nxt);
            end
          end
          OP_ERASE: begin
            if (hit_r) begin
              scan_nxt      = CW'(idx_r) + CW'(1);
              chk_valid_nxt = 1'b0;
            end else begin
              res_nxt.status = ST_MISSING;
            end
          end
          default: begin
            res_nxt.read_value = hit_r ? val_r : '0;
          end
        endcase
      end

      // Move each later entry down one place: read j+1, write j next cycle.
      S_SHIFT: begin
        if (chk_valid_r) begin
          mem_we    = 1'b1;
          mem_waddr = chk_idx_r - AW'(1);
          mem_wdata = mem_rdata;
        end
        if (scan_r < count_r) begin
          chk_valid_nxt = 1'b1;
          chk_idx_nxt   = scan_r[AW-1:0];
          scan_nxt      = scan_r + CW'(1);
        end else begin
          chk_valid_nxt = 1'b0;
          if (!chk_valid_r) begin
            count_nxt           = count_r - CW'(1);
            res_nxt.entry_total = TOTAL_W'(count_nxt);
          end
        end
      end

      S_DONE: begin
        res_valid = out_free;
      end

      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      chk_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_valid_r <= chk_valid_nxt;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    wval_r    <= wval_nxt;
    scan_r    <= scan_nxt;
    chk_idx_r <= chk_idx_nxt;
    hit_r     <= hit_nxt;
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    res_r     <= res_nxt;
  end

  assign res = res_r;

endmodule
